// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL core.
// Each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/sha256_pkg.sv -----
// Package for the SHA-256 stream hasher: word types, round constants, helpers.
// No dependencies.
`default_nettype none
package sha256_pkg;
    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;
    localparam int DigestWords = 8;

    localparam logic ACTION_ABSORB   = 1'b0;
    localparam logic ACTION_FINALIZE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] message_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    function automatic logic [31:0] initial_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level: byte packing into the schedule window, round unit.
// Depends on sha256_pkg and assert_macros.svh.
//
// An absorb word is taken whenever the hasher is idle. After the 64th byte of a block,
// the block is compressed by one shared round unit at one round per cycle, then
// folded into the chain value. A finalize word pads and compresses one or two blocks,
// then presents the eight digest words one per cycle as the output side takes them;
// stall is held high throughout.
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire sha256_pkg::in_word_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output sha256_pkg::out_word_t     out_data
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_PAD2  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  chain_reg [8];
    logic [31:0]  work_reg  [8];
    logic [31:0]  sched_reg [16];
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   round_reg;
    logic         final_reg;   // compression belongs to finalize
    logic         last_blk_reg; // this compression is the last one of finalize
    logic [2:0]   emit_reg;
    logic [63:0]  len_reg;

    logic         accept;
    logic [31:0]  w_cur, w_new, t1, t2, s0, s1, ss0, ss1, ch, maj;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Round datapath: current schedule word is slot 0 of the sliding window
    assign w_cur = sched_reg[0];
    assign ss0 = sha256_pkg::ror(sched_reg[1], 7) ^ sha256_pkg::ror(sched_reg[1], 18)
                 ^ (sched_reg[1] >> 3);
    assign ss1 = sha256_pkg::ror(sched_reg[14], 17) ^ sha256_pkg::ror(sched_reg[14], 19)
                 ^ (sched_reg[14] >> 10);
    assign w_new = ss1 + sched_reg[9] + ss0 + sched_reg[0];
    assign s1  = sha256_pkg::ror(work_reg[4], 6) ^ sha256_pkg::ror(work_reg[4], 11)
                 ^ sha256_pkg::ror(work_reg[4], 25);
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign s0  = sha256_pkg::ror(work_reg[0], 2) ^ sha256_pkg::ror(work_reg[0], 13)
                 ^ sha256_pkg::ror(work_reg[0], 22);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + s1 + ch + sha256_pkg::round_k(round_reg) + w_cur;
    assign t2  = s0 + maj;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.action == sha256_pkg::ACTION_ABSORB && fill_reg == 6'd63)
                    state_next = ST_ROUND;
                else if (accept && in_data.action == sha256_pkg::ACTION_FINALIZE)
                    state_next = ST_PAD;
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_PAD2:  state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
            begin
                if (!final_reg)         state_next = ST_IDLE;
                else if (last_blk_reg)  state_next = ST_EMIT;
                else                    state_next = ST_PAD2;
            end
            ST_EMIT:  if (!out_stall && emit_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            final_reg    <= 1'b0;
            last_blk_reg <= 1'b0;
            emit_reg     <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::initial_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    // Absorb a byte, or flag finalize and whether one block will hold the length
                    if (accept && in_data.action == sha256_pkg::ACTION_ABSORB)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            final_reg <= 1'b0;
                            round_reg <= '0;
                            bits_reg  <= bits_reg + 64'd512;
                        end
                    end
                    else if (accept)
                    begin
                        final_reg <= 1'b1;
                        round_reg <= '0;
                        last_blk_reg <= (fill_reg < 6'd56);
                    end
                end
                ST_PAD, ST_PAD2:
                begin
                    round_reg <= '0;
                    if (state_reg == ST_PAD2) last_blk_reg <= 1'b1;
                end
                ST_ROUND: round_reg <= round_reg + 6'd1;
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    fill_reg <= '0;
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            // Restart for next message
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= sha256_pkg::initial_hash(3'(i));
                            bits_reg  <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: bytes packed into the schedule window, working variables, length
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            if (in_data.action == sha256_pkg::ACTION_ABSORB)
            begin
                // Place the byte in its lane, first byte of a word in the top lane
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < 4; j++)
                        if ({4'(i), 2'(j)} == fill_reg)
                            sched_reg[i][31-8*j -: 8] <= in_data.message_byte;
                if (fill_reg == 6'd63)
                begin
                    for (int i = 0; i < 8; i++)
                        work_reg[i] <= chain_reg[i];
                end
            end
            else
            begin
                len_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
                // Mark the end of the message and clear the rest of the block
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < 4; j++)
                        if ({4'(i), 2'(j)} == fill_reg)
                            sched_reg[i][31-8*j -: 8] <= 8'h80;
                        else if ({4'(i), 2'(j)} > fill_reg)
                            sched_reg[i][31-8*j -: 8] <= 8'h00;
            end
        end
        else if (state_reg == ST_PAD || state_reg == ST_PAD2)
        begin
            // Clear the extra block; length goes last when this is the final block
            if (state_reg == ST_PAD2)
            begin
                for (int i = 0; i < 14; i++)
                    sched_reg[i] <= 32'd0;
            end
            if (state_reg == ST_PAD2 || last_blk_reg)
            begin
                sched_reg[14] <= len_reg[63:32];
                sched_reg[15] <= len_reg[31:0];
            end
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[15] <= w_new;
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // Present digest words
    assign out_valid = (state_reg == ST_EMIT);
    assign out_data.digest_word = chain_reg[emit_reg];
    assign out_data.word_index  = emit_reg;
    assign out_data.last_word   = (emit_reg == 3'd7);

    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_IMPLIES(a_emit_final, clk, rst_n, out_valid, final_reg)
    `ASSERT_NEXT(a_round_adv, clk, rst_n, state_reg == ST_ROUND && round_reg != 6'd63,
                 state_reg == ST_ROUND)
    `ASSERT_NEXT(a_emit_done, clk, rst_n, out_valid && !out_stall && emit_reg == 3'd7,
                 state_reg == ST_IDLE && emit_reg == 3'd0)
endmodule
`default_nettype wire
